/* sv/bdq_pkg.sv */
// shared types and constants for the byte deque with value erase
// depends on nothing; the deque and the address unit refer to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OCC_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK    = 3'd0,
    CMD_PUSH_FRONT   = 3'd1,
    CMD_REMOVE_FRONT = 3'd2,
    CMD_REMOVE_BACK  = 3'd3,
    CMD_REMOVE_MATCH = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_SRD  = 5'b01000,
    S_SWR  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             empty_res;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

endpackage

`default_nettype wire

/* sv/byte_deque_with_value_erase.sv */
// byte deque with value erase: ring buffer in ram, head pointer and count
// push/pop at either end: result valid in the cycle after accept
// remove-match: searches from the front (S_RD, S_CMP), then shifts each later
//   entry down one place (S_SRD, S_SWR), as the ram read is registered
// one item at a time; ready again in the cycle the result is presented, unless out_stall_i holds it
// reset clears the count, head and control; the ram is not cleared
`timescale 1ns / 1ps
`default_nettype none

module byte_deque_with_value_erase (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire bdq_pkg::in_item_t   in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      bdq_pkg::out_item_t  out_data_o
);

  bdq_pkg::state_e               state_q, state_d;
  logic [bdq_pkg::PTR_W-1:0]     head_q, head_d;
  logic [bdq_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [bdq_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [bdq_pkg::VAL_W-1:0]     val_q, val_d;
  logic                          out_valid_q, out_valid_d;
  bdq_pkg::out_item_t            out_data_q, out_data_d;

  logic                          accept;
  logic                          full;
  logic [bdq_pkg::CNT_W-1:0]     off;
  logic [bdq_pkg::PTR_W-1:0]     addr;
  logic                          we;
  logic [bdq_pkg::VAL_W-1:0]     wdata;
  logic [bdq_pkg::VAL_W-1:0]     rdata;
  logic                          res_load;
  logic [bdq_pkg::ST_W-1:0]      res_st;
  logic [bdq_pkg::CNT_W-1:0]     res_cnt;

  assign in_stall_o  = (state_q != bdq_pkg::S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign full        = (cnt_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // offset into the ring for the shared address unit
  always_comb begin
    off = '0;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        case (in_data_i.cmd)
          bdq_pkg::CMD_PUSH_BACK:    off = cnt_q;
          bdq_pkg::CMD_PUSH_FRONT:   off = bdq_pkg::CNT_W'(bdq_pkg::DEPTH - 1);
          bdq_pkg::CMD_REMOVE_FRONT: off = bdq_pkg::CNT_W'(1);
          default:                   off = '0;
        endcase
      end
      bdq_pkg::S_RD:  off = idx_q;
      bdq_pkg::S_SRD: off = idx_q + bdq_pkg::CNT_W'(1);
      bdq_pkg::S_SWR: off = idx_q;
      default:        off = '0;
    endcase
  end

  bdq_addr u_addr (
    .head_i (head_q),
    .off_i  (off),
    .addr_o (addr)
  );

  bdq_ram #(
    .WIDTH (bdq_pkg::VAL_W),
    .DEPTH (bdq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    val_d       = val_q;
    we          = 1'b0;
    wdata       = in_data_i.value;
    res_load    = 1'b0;
    res_st      = bdq_pkg::ST_DONE;
    res_cnt     = cnt_q;

    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (in_data_i.cmd)
            bdq_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                res_st = bdq_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                cnt_d   = cnt_q + bdq_pkg::CNT_W'(1);
                res_cnt = cnt_d;
              end
            end
            bdq_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                res_st = bdq_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                head_d  = addr;
                cnt_d   = cnt_q + bdq_pkg::CNT_W'(1);
                res_cnt = cnt_d;
              end
            end
            bdq_pkg::CMD_REMOVE_FRONT: begin
              if (cnt_q == '0) begin
                res_st = bdq_pkg::ST_EMPTY;
              end else begin
                head_d  = addr;
                cnt_d   = cnt_q - bdq_pkg::CNT_W'(1);
                res_cnt = cnt_d;
              end
            end
            bdq_pkg::CMD_REMOVE_BACK: begin
              if (cnt_q == '0) begin
                res_st = bdq_pkg::ST_EMPTY;
              end else begin
                cnt_d   = cnt_q - bdq_pkg::CNT_W'(1);
                res_cnt = cnt_d;
              end
            end
            bdq_pkg::CMD_REMOVE_MATCH: begin
              if (cnt_q == '0) begin
                res_st = bdq_pkg::ST_EMPTY;
              end else begin
                // search from the front, result comes at the end
                res_load = 1'b0;
                val_d    = in_data_i.value;
                idx_d    = '0;
                state_d  = bdq_pkg::S_RD;
              end
            end
            default: begin
              res_st = bdq_pkg::ST_DONE;
            end
          endcase
        end
      end
      bdq_pkg::S_RD: begin
        state_d = bdq_pkg::S_CMP;
      end
      bdq_pkg::S_CMP: begin
        if (rdata == val_q) begin
          if ((idx_q + bdq_pkg::CNT_W'(1)) == cnt_q) begin
            // match is the last entry, nothing to close up
            cnt_d    = cnt_q - bdq_pkg::CNT_W'(1);
            res_load = 1'b1;
            res_cnt  = cnt_d;
            state_d  = bdq_pkg::S_IDLE;
          end else begin
            state_d = bdq_pkg::S_SRD;
          end
        end else if ((idx_q + bdq_pkg::CNT_W'(1)) == cnt_q) begin
          res_load = 1'b1;
          res_st   = bdq_pkg::ST_NOTFOUND;
          state_d  = bdq_pkg::S_IDLE;
        end else begin
          idx_d   = idx_q + bdq_pkg::CNT_W'(1);
          state_d = bdq_pkg::S_RD;
        end
      end
      bdq_pkg::S_SRD: begin
        state_d = bdq_pkg::S_SWR;
      end
      bdq_pkg::S_SWR: begin
        // move entry idx+1 down into idx
        we    = 1'b1;
        wdata = rdata;
        if ((idx_q + bdq_pkg::CNT_W'(2)) == cnt_q) begin
          cnt_d    = cnt_q - bdq_pkg::CNT_W'(1);
          res_load = 1'b1;
          res_cnt  = cnt_d;
          state_d  = bdq_pkg::S_IDLE;
        end else begin
          idx_d   = idx_q + bdq_pkg::CNT_W'(1);
          state_d = bdq_pkg::S_SRD;
        end
      end
      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (res_load) begin
      out_valid_d          = 1'b1;
      out_data_d.status    = res_st;
      out_data_d.empty_res = (res_cnt == '0);
      out_data_d.occupancy = bdq_pkg::OCC_W'(res_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("entry count above depth");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bdq_pkg::S_IDLE) |-> in_stall_o)
    else $error("input taken while a search is running");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (in_data_i.cmd == bdq_pkg::CMD_PUSH_BACK ||
                        in_data_i.cmd == bdq_pkg::CMD_PUSH_FRONT))
    |=> (out_valid_q && out_data_q.status == bdq_pkg::ST_FULL && $stable(cnt_q)))
    else $error("push on full queue not refused");

  a_no_write_on_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdq_pkg::S_CMP || state_q == bdq_pkg::S_RD) |-> !we)
    else $error("ram written during search");

endmodule

`default_nettype wire

/* sv/bdq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies; contents are not reset
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/bdq_addr.sv */
// shared address unit: ring position of (head + offset) modulo DEPTH
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_addr (
  input  wire logic [bdq_pkg::PTR_W-1:0] head_i,
  input  wire logic [bdq_pkg::CNT_W-1:0] off_i,
  output      logic [bdq_pkg::PTR_W-1:0] addr_o
);

  logic [bdq_pkg::SUM_W-1:0] sum;
  logic [bdq_pkg::SUM_W-1:0] wrapped;

  always_comb begin
    sum = bdq_pkg::SUM_W'(head_i) + bdq_pkg::SUM_W'(off_i);
    // offset never exceeds DEPTH, so one subtract is enough
    if (sum >= bdq_pkg::SUM_W'(bdq_pkg::DEPTH)) begin
      wrapped = sum - bdq_pkg::SUM_W'(bdq_pkg::DEPTH);
    end else begin
      wrapped = sum;
    end
    addr_o = bdq_pkg::PTR_W'(wrapped);
  end

endmodule

`default_nettype wire
